>>> rtl/fmh_pkg.sv
// Shared types and constants for the FIFO mutex hand-off core.
// No dependencies; used by every module in rtl/.
`default_nettype none

package fmh_pkg;

  // Width of a thread identifier as carried on the ports.
  localparam int TID_BITS = 8;

  // Default wait queue depth.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Request opcodes
  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_BLOCKED   = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_HANDOFF   = 3'd3;
  localparam logic [2:0] ST_NOT_OWNER = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // commit the request and load the result register
  } fmh_cmd_t;

endpackage

`default_nettype wire

>>> rtl/fmh_datapath.sv
// Datapath: mutex state, wait queue memory, pointers and result register.
// Depends on fmh_pkg; driven by fmh_ctrl through fmh_cmd_t.
`default_nettype none

module fmh_datapath import fmh_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fmh_cmd_t            cmd,
  input  wire logic                opcode,
  input  wire logic [TID_BITS-1:0] thread_id,
  output logic [2:0]               status,
  output logic                     woken_valid,
  output logic [TID_BITS-1:0]      woken_thread,
  output logic                     is_locked,
  output logic [TID_BITS-1:0]      current_owner,
  output logic [CNT_W-1:0]         waiting_count
);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  logic                op_r;
  logic [TID_BITS-1:0] tid_r;

  logic                held, held_next;
  logic [TID_BITS-1:0] owner, owner_next;
  logic [PTR_W-1:0]    head, head_next;
  logic [PTR_W-1:0]    tail, tail_next;
  logic [CNT_W-1:0]    count, count_next;

  logic [TID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [TID_BITS-1:0] rd_data;
  logic                mem_we;

  logic [2:0]          status_next;
  logic                woken_next;

  always_comb begin
    held_next   = held;
    owner_next  = owner;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    mem_we      = 1'b0;
    woken_next  = 1'b0;
    status_next = ST_NOT_OWNER;
    if (op_r == OP_LOCK) begin
      priority if (!held) begin
        held_next   = 1'b1;
        owner_next  = tid_r;
        status_next = ST_ACQUIRED;
      end else if (count == FULL_CNT) begin
        status_next = ST_FULL;
      end else begin
        mem_we      = 1'b1;
        tail_next   = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
        count_next  = count + 1'b1;
        status_next = ST_BLOCKED;
      end
    end else begin
      priority if (!held || owner != tid_r) begin
        status_next = ST_NOT_OWNER;
      end else if (count != '0) begin
        // head word was read out of the queue while the request was captured
        owner_next  = rd_data;
        head_next   = (head == LAST_SLOT) ? '0 : head + 1'b1;
        count_next  = count - 1'b1;
        woken_next  = 1'b1;
        status_next = ST_HANDOFF;
      end else begin
        held_next   = 1'b0;
        owner_next  = '0;
        status_next = ST_RELEASED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      held  <= held_next;
      owner <= owner_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      tid_r <= thread_id;
    end
  end

  // Wait queue memory: one write port at tail, registered read at head.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[tail] <= tid_r;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= status_next;
      woken_valid   <= woken_next;
      woken_thread  <= woken_next ? rd_data : '0;
      is_locked     <= held_next;
      current_owner <= owner_next;
      waiting_count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fmh_ctrl.sv
// Controller: request sequencing and output word valid.
// Depends on fmh_pkg; issues fmh_cmd_t to fmh_datapath.
`default_nettype none

module fmh_ctrl import fmh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output fmh_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   fire;

  assign in_ready = (state == S_IDLE);
  // commit only once the result register is free or being emptied
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fifo_mutex_handoff_core.sv
// Top level of the FIFO mutex hand-off core.
// Depends on fmh_pkg, fmh_ctrl and fmh_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: opcode
//   (lock or unlock) and thread_id. Output channel (out_valid/out_ready)
//   returns exactly one result word per request: status, woken thread on
//   a hand-off, lock state, owner and wait queue occupancy.
//   Each request is captured first, while the queue head is read through
//   the registered memory port, and then committed: the state update is
//   loaded into the output register and out_valid rises. No new request
//   is accepted until the previous one has committed.
//   A new request is accepted while the previous result waits in the
//   output register; if the receiver stalls, the request holds in its
//   commit cycle until the output register drains, and in_ready stays low.
//   Reset (rst, synchronous) frees the mutex and empties the queue; the
//   queue memory itself is not cleared, only entries written are read.
`default_nettype none

module fifo_mutex_handoff_core import fmh_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                opcode,
  input  wire logic [TID_BITS-1:0] thread_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic                     woken_valid,
  output logic [TID_BITS-1:0]      woken_thread,
  output logic                     is_locked,
  output logic [TID_BITS-1:0]      current_owner,
  output logic [CNT_W-1:0]         waiting_count
);

  fmh_cmd_t cmd;

  fmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fmh_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .thread_id     (thread_id),
    .status        (status),
    .woken_valid   (woken_valid),
    .woken_thread  (woken_thread),
    .is_locked     (is_locked),
    .current_owner (current_owner),
    .waiting_count (waiting_count)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_handoff_owner: assert property (@(posedge clk) disable iff (rst)
    out_valid && woken_valid |->
      status == ST_HANDOFF && is_locked && current_owner == woken_thread)
    else $error("hand-off word inconsistent");

  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_locked |-> current_owner == '0 && waiting_count == '0)
    else $error("free mutex with owner or waiters");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> waiting_count <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count above queue depth");

endmodule

`default_nettype wire

>>> dv/tb_fifo_mutex_handoff_core.sv
// Self-checking testbench for fifo_mutex_handoff_core: lock/unlock words in,
// one result word out per request, checked against an in-bench mutex model.
// Depends on rtl/fmh_pkg.sv and rtl/fifo_mutex_handoff_core.sv.
`timescale 1ns / 100ps

module tb_fifo_mutex_handoff_core;
  import fmh_pkg::*;

  localparam int Q_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int CNT_W      = $clog2(Q_DEPTH + 1);
  localparam int N_RANDOM   = 1925;
  localparam int STALL_LIM  = 1000;
  localparam int HOLD_LEN   = 150;
  localparam int HOLD_AT    = 1200;
  localparam int QUIET_LO   = 600;
  localparam int QUIET_HI   = 1000;
  localparam int IDLE_PCT   = 11;

  typedef struct packed {
    logic                op;
    logic [TID_BITS-1:0] tid;
    logic                sync;  // wait for all results before offering
  } request_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                woken_valid;
    logic [TID_BITS-1:0] woken_thread;
    logic                is_locked;
    logic [TID_BITS-1:0] current_owner;
    logic [CNT_W-1:0]    waiting_count;
  } grant_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_LOCK;
  logic [TID_BITS-1:0] thread_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          status;
  logic                woken_valid;
  logic [TID_BITS-1:0] woken_thread;
  logic                is_locked;
  logic [TID_BITS-1:0] current_owner;
  logic [CNT_W-1:0]    waiting_count;

  fifo_mutex_handoff_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .thread_id     (thread_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .woken_valid   (woken_valid),
    .woken_thread  (woken_thread),
    .is_locked     (is_locked),
    .current_owner (current_owner),
    .waiting_count (waiting_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t request_q[$];
  grant_t   grant_q[$];
  int       err_cnt = 0;

  // Mutex model state
  logic                m_held = 1'b0;
  logic [TID_BITS-1:0] m_owner = '0;
  logic [TID_BITS-1:0] m_waitq [Q_DEPTH];
  int                  m_head = 0;
  int                  m_tail = 0;
  int                  m_count = 0;

  task automatic mutex_predict(input logic op, input logic [TID_BITS-1:0] tid);
    grant_t g;
    g = '0;
    if (op == OP_LOCK) begin
      if (!m_held) begin
        m_held = 1'b1;
        m_owner = tid;
        g.status = ST_ACQUIRED;
      end else if (m_count >= Q_DEPTH) begin
        g.status = ST_FULL;
      end else begin
        // owner relocking is queued behind itself like anyone else
        m_waitq[m_tail] = tid;
        m_tail = (m_tail + 1) % Q_DEPTH;
        m_count++;
        g.status = ST_BLOCKED;
      end
    end else begin
      if (!m_held || m_owner != tid) begin
        g.status = ST_NOT_OWNER;
      end else if (m_count != 0) begin
        g.woken_thread = m_waitq[m_head];
        g.woken_valid = 1'b1;
        m_owner = m_waitq[m_head];
        m_head = (m_head + 1) % Q_DEPTH;
        m_count--;
        g.status = ST_HANDOFF;
      end else begin
        m_held = 1'b0;
        m_owner = '0;
        g.status = ST_RELEASED;
      end
    end
    g.is_locked = m_held;
    g.current_owner = m_held ? m_owner : '0;
    g.waiting_count = m_count[CNT_W-1:0];
    grant_q.push_back(g);
  endtask

  task automatic add_request(input logic op, input logic [TID_BITS-1:0] tid,
                             input logic sync);
    request_t r;
    r.op = op;
    r.tid = tid;
    r.sync = sync;
    request_q.push_back(r);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Driver
  request_t nxt_req;
  int       n_sent = 0;
  logic     tx_idle;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      opcode <= OP_LOCK;
      thread_id <= '0;
    end else begin
      if (in_valid && in_ready) begin
        mutex_predict(opcode, thread_id);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        tx_idle = ($urandom_range(0, 99) < IDLE_PCT) &&
                  !(n_sent >= QUIET_LO && n_sent < QUIET_HI);
        if (request_q.size() != 0 && !tx_idle &&
            !(request_q[0].sync && grant_q.size() != 0)) begin
          nxt_req = request_q.pop_front();
          opcode <= nxt_req.op;
          thread_id <= nxt_req.tid;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  grant_t exp_g;
  int     n_out = 0;
  int     hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, status);
          err_cnt++;
        end else begin
          exp_g = grant_q.pop_front();
          cmp_field("status", 32'(exp_g.status), 32'(status));
          cmp_field("woken_valid", 32'(exp_g.woken_valid), 32'(woken_valid));
          cmp_field("woken_thread", 32'(exp_g.woken_thread), 32'(woken_thread));
          cmp_field("is_locked", 32'(exp_g.is_locked), 32'(is_locked));
          cmp_field("current_owner", 32'(exp_g.current_owner), 32'(current_owner));
          cmp_field("waiting_count", 32'(exp_g.waiting_count), 32'(waiting_count));
        end
        if (n_out == HOLD_AT)
          hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (n_out >= QUIET_LO && n_out < QUIET_HI) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  int stall_cnt = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIM) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Stimulus
  initial begin
    int                  n_gen;
    int                  phase_left;
    int                  lock_pct;
    int                  pool_base;
    int                  pool_size;
    logic                op;
    logic [TID_BITS-1:0] tid;
    logic                sync;

    n_gen = 0;
    phase_left = 0;
    lock_pct = 50;
    pool_base = 0;
    pool_size = 2;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: free unlock, relock by owner, non-owner unlock, hand-offs,
    // release, then fill the queue and overflow it
    add_request(OP_UNLOCK, 8'd0, 1'b0);
    add_request(OP_LOCK, 8'd255, 1'b0);
    add_request(OP_LOCK, 8'd255, 1'b0);
    add_request(OP_LOCK, 8'd0, 1'b0);
    add_request(OP_UNLOCK, 8'd0, 1'b0);
    add_request(OP_UNLOCK, 8'd255, 1'b0);
    add_request(OP_UNLOCK, 8'd255, 1'b0);
    add_request(OP_UNLOCK, 8'd0, 1'b0);
    add_request(OP_LOCK, 8'h5a, 1'b0);
    for (int i = 0; i < Q_DEPTH; i++)
      add_request(OP_LOCK, 8'(i * 17), 1'b0);
    add_request(OP_LOCK, 8'ha5, 1'b0);

    while (n_gen < N_RANDOM) begin
      @(negedge clk);
      if (request_q.size() < 2) begin
        sync = 1'b0;
        if (phase_left == 0) begin
          phase_left = $urandom_range(60, 160);
          case ($urandom_range(0, 2))
            0: lock_pct = 20;
            1: lock_pct = 50;
            default: lock_pct = 85;
          endcase
          pool_size = $urandom_range(2, 6);
          pool_base = $urandom_range(0, 255 - pool_size);
          sync = (n_gen == 0) || ($urandom_range(0, 2) == 0);
        end
        phase_left--;
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything goes
          op = 1'($urandom_range(0, 1));
          tid = 8'($urandom_range(0, 255));
        end else begin
          op = ($urandom_range(0, 99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
          tid = 8'(pool_base + $urandom_range(0, pool_size - 1));
          // mostly unlock as the owner so hand-offs and releases happen
          if (op == OP_UNLOCK && m_held && $urandom_range(0, 99) < 80)
            tid = m_owner;
        end
        add_request(op, tid, sync);
        n_gen++;
      end
    end

    while (request_q.size() != 0 || in_valid || grant_q.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
